/* sv/sha1h_pkg.sv */
// shared types, constants and round functions of the sha-1 message hasher
`default_nettype none
package sha1h_pkg;

   localparam int WordBits   = 32;
   localparam int BlockWords = 16;
   localparam int AddrBits   = $clog2(BlockWords);
   localparam int HashWords  = 5;
   localparam int Rounds     = 80;

   typedef logic [WordBits-1:0]  word_type;
   typedef logic [AddrBits-1:0]  addr_type;
   typedef logic [6:0]           round_type;
   typedef logic [2:0]           windex_type;
   typedef word_type [HashWords-1:0] hash_type;

   localparam hash_type HashInit = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [7:0] PadByte   = 8'h80;
   localparam windex_type LastIndex = 3'd4;
   localparam windex_type DoneIndex = 3'd5;
   localparam addr_type   LastAddr  = 4'd15;
   localparam addr_type   LenHiAddr = 4'd14;
   localparam round_type  LastRound = 7'd79;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_item_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      word_type data;
   } mem_wr_type;

   typedef struct packed {
      addr_type addr0;
      addr_type addr1;
   } mem_rd_type;

   typedef struct packed {
      logic      load;
      logic      step;
      round_type round;
   } round_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_PRIME,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   function automatic word_type rotl1(input word_type x);
      return {x[WordBits-2:0], x[WordBits-1]};
   endfunction

   function automatic word_type round_const(input round_type t);
      word_type k;
      if (t < 7'd20) begin
         k = 32'h5A827999;
      end else if (t < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (t < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

   function automatic word_type round_func(input round_type t, input word_type b,
                                           input word_type c, input word_type d);
      word_type f;
      if (t < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (t < 7'd40 || t >= 7'd60) begin
         f = b ^ c ^ d;
      end else begin
         f = (b & c) | (b & d) | (c & d);
      end
      return f;
   endfunction

endpackage
`default_nettype wire

/* sv/sha1_message_hasher.sv */
// sha-1 message hasher top level: byte intake, padding, round control, digest output
// an item is taken only in the idle state; a full 64-byte block then adds a
// read-prime step, 80 rounds at one per cycle and a fold step; the rate is
// set by the single round datapath.
// the end of a message adds pad writes and one or two compressions,
// then five digest words, one per cycle when not stalled.
// synchronous reset restores the initial hash words and a zero bit count.
`default_nettype none
module sha1_message_hasher (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  sha1h_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output sha1h_pkg::rsp_item_type rsp_item
);
   import sha1h_pkg::*;

   state_type      state_ff, state_in;
   logic [63:0]    count_ff, count_in;
   word_type       acc_ff;
   hash_type       hash_ff;
   round_type      round_ff;
   addr_type       pad_wi_ff;
   logic           mark_ff, len_here_ff, pad_begun_ff, len_done_ff, fin_ff;
   logic           rsp_valid_ff;
   rsp_item_type   rsp_ff;
   windex_type     load_idx_ff;

   logic           req_accept, rsp_accept, rsp_load;
   addr_type       pad_wi_entry;
   logic           len_here_entry;
   word_type       pad_data, merged_word, sched_word;
   word_type       qa0, qa1, qb0, qb1;
   mem_wr_type     mem_wr;
   mem_rd_type     rd_a, rd_b;
   round_ctrl_type round_ctrl;
   hash_type       work;
   addr_type       tl;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_ff;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_accept)
                       && (load_idx_ff != DoneIndex);

   always_comb begin
      count_in = count_ff;
      if (state_ff == ST_IDLE && req_accept && req_item.byte_present) begin
         count_in = count_ff + 64'd8;
      end else if (state_ff == ST_OUT && rsp_accept && rsp_ff.last_word) begin
         count_in = '0;
      end
   end

   assign pad_wi_entry   = pad_begun_ff ? '0 : count_in[8:5];
   assign len_here_entry = pad_begun_ff ? 1'b1 : (count_in[8:3] < 6'd56);

   always_comb begin
      case (count_ff[4:3])
         2'd0:    merged_word = {PadByte, 24'h0};
         2'd1:    merged_word = {acc_ff[7:0], PadByte, 16'h0};
         2'd2:    merged_word = {acc_ff[15:0], PadByte, 8'h0};
         default: merged_word = {acc_ff[23:0], PadByte};
      endcase
   end

   always_comb begin
      if (mark_ff) begin
         pad_data = merged_word;
      end else if (len_here_ff && pad_wi_ff == LenHiAddr) begin
         pad_data = count_ff[63:32];
      end else if (len_here_ff && pad_wi_ff == LastAddr) begin
         pad_data = count_ff[31:0];
      end else begin
         pad_data = '0;
      end
   end

   assign sched_word = (round_ff < 7'd16) ? qa0 : rotl1(qa0 ^ qa1 ^ qb0 ^ qb1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_item.byte_present && count_ff[8:3] == 6'd63) begin
                  state_in = ST_PRIME;
               end else if (req_item.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (pad_wi_ff == LastAddr) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: state_in = ST_ROUND;
         ST_ROUND: begin
            if (round_ff == LastRound) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (len_done_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_accept && rsp_ff.last_word) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory and round control
   always_comb begin
      tl = round_ff[AddrBits-1:0];
      mem_wr     = '0;
      rd_a       = '0;
      rd_b       = '0;
      round_ctrl = '0;
      round_ctrl.round = round_ff;
      case (state_ff)
         ST_IDLE: begin
            mem_wr.en   = req_accept && req_item.byte_present && (count_ff[4:3] == 2'd3);
            mem_wr.addr = count_ff[8:5];
            mem_wr.data = {acc_ff[23:0], req_item.data_byte};
         end
         ST_PAD: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = pad_wi_ff;
            mem_wr.data = pad_data;
         end
         ST_PRIME: begin
            round_ctrl.load = 1'b1;
         end
         ST_ROUND: begin
            round_ctrl.step = 1'b1;
            mem_wr.en   = (round_ff >= 7'd16);
            mem_wr.addr = tl;
            mem_wr.data = sched_word;
            rd_a.addr0  = tl + 4'd1;
            rd_a.addr1  = tl + 4'd14;
            rd_b.addr0  = tl + 4'd9;
            rd_b.addr1  = tl + 4'd3;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         hash_ff      <= HashInit;
         round_ff     <= '0;
         pad_wi_ff    <= '0;
         mark_ff      <= 1'b0;
         len_here_ff  <= 1'b0;
         pad_begun_ff <= 1'b0;
         len_done_ff  <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         load_idx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_in == ST_PAD && state_ff != ST_PAD) begin
            pad_wi_ff    <= pad_wi_entry;
            mark_ff      <= !pad_begun_ff;
            len_here_ff  <= len_here_entry;
            pad_begun_ff <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  fin_ff <= req_item.end_of_message;
               end
            end
            ST_PAD: begin
               mark_ff <= 1'b0;
               if (pad_wi_ff == LastAddr) begin
                  len_done_ff <= len_here_ff;
               end else begin
                  pad_wi_ff <= pad_wi_ff + 4'd1;
               end
            end
            ST_PRIME: round_ff <= '0;
            ST_ROUND: begin
               round_ff <= (round_ff == LastRound) ? '0 : round_ff + 7'd1;
            end
            ST_FOLD: begin
               for (int k = 0; k < HashWords; k++) begin
                  hash_ff[k] <= hash_ff[k] + work[k];
               end
               load_idx_ff  <= '0;
               rsp_valid_ff <= 1'b0;
            end
            ST_OUT: begin
               if (rsp_load) begin
                  rsp_valid_ff <= 1'b1;
                  load_idx_ff  <= load_idx_ff + 3'd1;
               end else if (rsp_accept) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (rsp_accept && rsp_ff.last_word) begin
                  hash_ff      <= HashInit;
                  fin_ff       <= 1'b0;
                  pad_begun_ff <= 1'b0;
                  len_done_ff  <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_accept && req_item.byte_present) begin
         acc_ff <= {acc_ff[23:0], req_item.data_byte};
      end
      if (rsp_load) begin
         rsp_ff.digest_word <= hash_ff[load_idx_ff];
         rsp_ff.word_index  <= load_idx_ff;
         rsp_ff.last_word   <= (load_idx_ff == LastIndex);
      end
   end

   sha1h_mem u_mem_a (
      .clock       (clock),
      .wr          (mem_wr),
      .rd          (rd_a),
      .rd_data0_ff (qa0),
      .rd_data1_ff (qa1)
   );

   sha1h_mem u_mem_b (
      .clock       (clock),
      .wr          (mem_wr),
      .rd          (rd_b),
      .rd_data0_ff (qb0),
      .rd_data1_ff (qb1)
   );

   sha1h_round u_round (
      .clock      (clock),
      .ctrl       (round_ctrl),
      .hash       (hash_ff),
      .sched_word (sched_word),
      .work_ff    (work)
   );

endmodule
`default_nettype wire

/* sv/sha1h_mem.sv */
// block store copy: one write port, two registered read ports
`default_nettype none
module sha1h_mem (
   input  wire                   clock,
   input  sha1h_pkg::mem_wr_type wr,
   input  sha1h_pkg::mem_rd_type rd,
   output sha1h_pkg::word_type   rd_data0_ff,
   output sha1h_pkg::word_type   rd_data1_ff
);
   import sha1h_pkg::*;

   word_type mem_ff [BlockWords];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data0_ff <= mem_ff[rd.addr0];
      rd_data1_ff <= mem_ff[rd.addr1];
   end

endmodule
`default_nettype wire

/* sv/sha1h_round.sv */
// working words a..e and the sha-1 round datapath
`default_nettype none
module sha1h_round (
   input  wire                       clock,
   input  sha1h_pkg::round_ctrl_type ctrl,
   input  sha1h_pkg::hash_type       hash,
   input  sha1h_pkg::word_type       sched_word,
   output sha1h_pkg::hash_type       work_ff
);
   import sha1h_pkg::*;

   hash_type work_in;
   word_type temp;

   always_comb begin
      temp = {work_ff[0][WordBits-6:0], work_ff[0][WordBits-1:WordBits-5]}
           + round_func(ctrl.round, work_ff[1], work_ff[2], work_ff[3])
           + work_ff[4] + round_const(ctrl.round) + sched_word;
      work_in = work_ff;
      if (ctrl.load) begin
         work_in = hash;
      end else if (ctrl.step) begin
         work_in[4] = work_ff[3];
         work_in[3] = work_ff[2];
         work_in[2] = {work_ff[1][1:0], work_ff[1][WordBits-1:2]};
         work_in[1] = work_ff[0];
         work_in[0] = temp;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

endmodule
`default_nettype wire

/* tb/sv/tb_sha1_message_hasher.sv */
// testbench for the sha-1 message hasher: byte stream stimulus, digest prediction and checking
`timescale 1ns / 1ps
module tb_sha1_message_hasher;
   import sha1h_pkg::*;

   localparam int IdleLimit   = 5000;
   localparam int HoldCycles  = 400;
   localparam int TargetItems = 500;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   class digest_scoreboard;
      word_type     hash_state [5];
      word_type     block_words [16];
      logic [63:0]  bit_total;
      rsp_item_type expected_words [$];
      int           mismatch_count;

      function new();
         mismatch_count = 0;
         start_message();
      endfunction

      function void start_message();
         hash_state[0] = 32'h67452301;
         hash_state[1] = 32'hEFCDAB89;
         hash_state[2] = 32'h98BADCFE;
         hash_state[3] = 32'h10325476;
         hash_state[4] = 32'hC3D2E1F0;
         bit_total = '0;
      endfunction

      function word_type rotl(input word_type x, input int n);
         return (x << n) | (x >> (32 - n));
      endfunction

      function void put_byte(input int pos, input logic [7:0] b);
         int wi;
         int sh;
         wi = pos / 4;
         sh = (3 - (pos % 4)) * 8;
         if (pos % 4 == 0) begin
            block_words[wi] = {b, 24'h000000};
         end else begin
            block_words[wi] = block_words[wi] | (word_type'(b) << sh);
         end
      endfunction

      function void compress_block();
         word_type sched [80];
         word_type a, b, c, d, e, f, k, tmp;
         int t;
         for (t = 0; t < 16; t++) sched[t] = block_words[t];
         for (t = 16; t < 80; t++) begin
            sched[t] = rotl(sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16], 1);
         end
         a = hash_state[0];
         b = hash_state[1];
         c = hash_state[2];
         d = hash_state[3];
         e = hash_state[4];
         for (t = 0; t < 80; t++) begin
            if (t < 20) begin
               f = (b & c) | (~b & d);
               k = 32'h5A827999;
            end else if (t < 40) begin
               f = b ^ c ^ d;
               k = 32'h6ED9EBA1;
            end else if (t < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = 32'h8F1BBCDC;
            end else begin
               f = b ^ c ^ d;
               k = 32'hCA62C1D6;
            end
            tmp = rotl(a, 5) + f + e + k + sched[t];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
         end
         hash_state[0] += a;
         hash_state[1] += b;
         hash_state[2] += c;
         hash_state[3] += d;
         hash_state[4] += e;
      endfunction

      function void absorb(input req_item_type it);
         int pos;
         int k;
         rsp_item_type w;
         if (it.byte_present) begin
            pos = int'(bit_total[8:3]);
            put_byte(pos, it.data_byte);
            bit_total += 64'd8;
            if (pos == 63) compress_block();
         end
         if (!it.end_of_message) return;
         pos = int'(bit_total[8:3]);
         put_byte(pos, 8'h80);
         pos++;
         if (pos > 56) begin
            while (pos < 64) begin
               put_byte(pos, 8'h00);
               pos++;
            end
            compress_block();
            pos = 0;
         end
         while (pos < 56) begin
            put_byte(pos, 8'h00);
            pos++;
         end
         block_words[14] = bit_total[63:32];
         block_words[15] = bit_total[31:0];
         compress_block();
         for (k = 0; k < 5; k++) begin
            w.digest_word = hash_state[k];
            w.word_index  = 3'(k);
            w.last_word   = (k == 4);
            expected_words.push_back(w);
         end
         start_message();
      endfunction

      function void check_digest_word(input rsp_item_type got);
         rsp_item_type want;
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected digest word %h idx %0d last %0b",
                        got.digest_word, got.word_index, got.last_word);
            end
            return;
         end
         want = expected_words.pop_front();
         if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
             got.last_word !== want.last_word) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                        want.digest_word, want.word_index, want.last_word,
                        got.digest_word, got.word_index, got.last_word);
            end
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   digest_scoreboard sb;
   int             burst_left = 0;
   int             items_sent = 0;
   int             idle_cycles = 0;
   bit             hold_wanted = 1'b0;
   bit             hold_done = 1'b0;
   int             hold_left = 0;
   int             mode_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   sha1_message_hasher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (hold_wanted && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 96);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= ~rsp_stall;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_digest_word(rsp_item);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic req_item_type make_item(input logic [7:0] b, input bit present,
                                              input bit eom);
      req_item_type it;
      it.data_byte      = b;
      it.byte_present   = present;
      it.end_of_message = eom;
      return it;
   endfunction

   task automatic send_item(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!(req_valid && !req_stall));
      burst_left--;
      if (it.byte_present || it.end_of_message) items_sent++;
      sb.absorb(it);
   endtask

   task automatic send_message(input int len, input bit eom_alone, input bit with_noise);
      int i;
      for (i = 0; i < len; i++) begin
         if (with_noise && $urandom_range(0, 7) == 0) begin
            send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
         end
         send_item(make_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !eom_alone));
      end
      if (len == 0 || eom_alone) send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
   endtask

   task automatic wait_for_digests();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_words.size() > 0) @(posedge clock);
   endtask

   initial begin
      int len;
      bit paused_once;
      int boundary_lengths [8];
      boundary_lengths = '{55, 56, 57, 63, 64, 65, 119, 128};
      paused_once = 1'b0;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty item, empty message, single-byte extremes, "abc", separate end flag
      send_item(make_item(8'hA5, 1'b0, 1'b0));
      send_item(make_item(8'h5A, 1'b0, 1'b1));
      send_item(make_item(8'h00, 1'b1, 1'b1));
      send_item(make_item(8'hFF, 1'b1, 1'b1));
      send_item(make_item(8'h61, 1'b1, 1'b0));
      send_item(make_item(8'h62, 1'b1, 1'b0));
      send_item(make_item(8'h63, 1'b1, 1'b1));
      send_item(make_item(8'h5A, 1'b1, 1'b0));
      send_item(make_item(8'hFF, 1'b0, 1'b0));
      send_item(make_item(8'h00, 1'b0, 1'b1));
      wait_for_digests();

      hold_wanted = 1'b1;
      while (items_sent < TargetItems) begin
         case ($urandom_range(0, 9))
            0: len = boundary_lengths[$urandom_range(0, 7)];
            1: len = $urandom_range(0, 3);
            default: len = $urandom_range(1, 40);
         endcase
         send_message(len, $urandom_range(0, 1), $urandom_range(0, 3) == 0);
         if (!paused_once && items_sent >= TargetItems / 2) begin
            wait_for_digests();
            paused_once = 1'b1;
         end
      end

      wait_for_digests();
      repeat (200) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.expected_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
